// ===== hdl/keyframe_segment_lookup_assert.svh =====
// -----------------------------------------------------------------------------
// keyframe_segment_lookup assertion macros
// Concurrent assertion helpers, clocked on the rising edge, off during reset.
// -----------------------------------------------------------------------------
`ifndef KEYFRAME_SEGMENT_LOOKUP_ASSERT_SVH
`define KEYFRAME_SEGMENT_LOOKUP_ASSERT_SVH

// same-cycle implication
`define KFSL_ASSERT_IMP(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) \
		else $error(msg);

// next-cycle implication
`define KFSL_ASSERT_NXT(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) \
		else $error(msg);

`endif

// ===== hdl/kfsl_pkg.sv =====
// -----------------------------------------------------------------------------
// kfsl_pkg
// Shared widths, codes and controller/datapath interface types.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kfsl_pkg;

	localparam int TIME_W      = 32;
	localparam int FRAC_W      = 17;
	localparam int KIDX_W      = 4;
	localparam int CNT_W       = 5;
	localparam int STEP_W      = 6;
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 96;

	localparam logic [FRAC_W-1:0] FRAC_ONE   = 17'h10000;
	localparam logic [STEP_W-1:0] MOD_STEPS  = 6'd32;
	localparam logic [STEP_W-1:0] FRAC_STEPS = 6'd17;

	typedef logic [1:0] rd_sel_t;
	localparam rd_sel_t RD_LAST = 2'd0;
	localparam rd_sel_t RD_ZERO = 2'd1;
	localparam rd_sel_t RD_ONE  = 2'd2;
	localparam rd_sel_t RD_NEXT = 2'd3;

	typedef logic [2:0] res_sel_t;
	localparam res_sel_t RES_ZERO   = 3'd0;
	localparam res_sel_t RES_EMPTY  = 3'd1;
	localparam res_sel_t RES_FIRST  = 3'd2;
	localparam res_sel_t RES_LAST   = 3'd3;
	localparam res_sel_t RES_HIT    = 3'd4;
	localparam res_sel_t RES_INTERP = 3'd5;

	typedef struct packed {
		logic     accept;
		logic     lat_end;
		logic     lat_first;
		logic     set_one;
		logic     start_mod;
		logic     mod_take;
		logic     step;
		logic     start_frac;
		logic     res_load;
		res_sel_t res_sel;
		rd_sel_t  rd_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic in_lookup;
		logic n_zero;
		logic early;
		logic past_end;
		logic loop_on;
		logic hit;
		logic at_last;
		logic inverted;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/kfsl_div.sv =====
// -----------------------------------------------------------------------------
// kfsl_div
// Radix-2 restoring divider, one quotient bit per cycle, loadable remainder.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfsl_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [kfsl_pkg::TIME_W-1:0]  init_rem,
	input  logic [kfsl_pkg::TIME_W-1:0]  init_dvd,
	input  logic [kfsl_pkg::TIME_W-1:0]  divisor,
	input  logic [kfsl_pkg::STEP_W-1:0]  steps,
	output logic                         done,
	output logic [kfsl_pkg::TIME_W-1:0]  rem,
	output logic [kfsl_pkg::FRAC_W-1:0]  quo
);
	import kfsl_pkg::*;

	logic [TIME_W-1:0] rem_q, dvd_q, dvs_q;
	logic [FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q, done_q;
	logic [TIME_W:0]   trial;
	logic              ge;

	always_comb begin
		trial = {rem_q, dvd_q[TIME_W-1]};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			dvd_q <= init_dvd;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? TIME_W'(trial - {1'b0, dvs_q}) : trial[TIME_W-1:0];
			dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
	assign quo  = quo_q;

endmodule

// ===== hdl/kfsl_datapath.sv =====
// -----------------------------------------------------------------------------
// kfsl_datapath
// Key table, lookup registers, compares, shared divider and output register.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfsl_datapath #(
	parameter int MAX_KEYS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [kfsl_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic [0:0]                        s_tuser,
	input  logic                              cfg_valid,
	input  logic [kfsl_pkg::CNT_W-1:0]        cfg_data,
	input  logic                              m_tready,
	input  kfsl_pkg::cmd_t                    cmd,
	output kfsl_pkg::sts_t                    sts,
	output logic                              m_tvalid,
	output logic [kfsl_pkg::OUT_TDATA_W-1:0]  m_tdata,
	output logic [0:0]                        m_tuser
);
	import kfsl_pkg::*;

	localparam int AW = $clog2(MAX_KEYS);

	logic [TIME_W-1:0] key_mem_q [MAX_KEYS];
	logic [TIME_W-1:0] rd_data_q;

	logic [CNT_W-1:0]  key_count_q;
	logic [CNT_W-1:0]  n_act, last_idx, rd_idx;
	logic [AW-1:0]     rd_addr;

	logic [KIDX_W-1:0] in_key_index;
	logic [TIME_W-1:0] in_key_time, in_pass_time;
	logic              in_loop, wr_en;

	logic [TIME_W-1:0] t_q, end_q, prev_q, gap_q, off_q;
	logic              loop_q;
	logic [CNT_W-1:0]  idx_q;
	logic [TIME_W-1:0] off_c, gap_c;

	logic              div_start, div_done;
	logic [TIME_W-1:0] div_init_rem, div_init_dvd, div_divisor, div_rem;
	logic [STEP_W-1:0] div_steps;
	logic [FRAC_W-1:0] div_quo;

	logic              res_status_q;
	logic [KIDX_W-1:0] res_base_q, res_next_q;
	logic [FRAC_W-1:0] res_frac_q;
	logic [TIME_W-1:0] res_rest_q, res_gap_q;

	logic              res_status_d;
	logic [KIDX_W-1:0] res_base_d, res_next_d;
	logic [FRAC_W-1:0] res_frac_d;
	logic [TIME_W-1:0] res_rest_d, res_gap_d;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic                   m_status_q;

	assign in_key_index = s_tdata[3:0];
	assign in_key_time  = s_tdata[35:4];
	assign in_pass_time = s_tdata[67:36];
	assign in_loop      = s_tdata[68];

	always_comb begin
		if (32'(key_count_q) > MAX_KEYS)
			n_act = CNT_W'(MAX_KEYS);
		else
			n_act = key_count_q;
		last_idx = n_act - CNT_W'(1);
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST: rd_idx = last_idx;
			RD_ZERO: rd_idx = '0;
			RD_ONE:  rd_idx = CNT_W'(1);
			RD_NEXT: rd_idx = idx_q + CNT_W'(1);
			default: rd_idx = '0;
		endcase
		rd_addr = AW'(rd_idx);
	end

	assign wr_en = cmd.accept && !s_tuser[0] && ({1'b0, in_key_index} < n_act);

	always_ff @(posedge clk) begin
		if (wr_en)
			key_mem_q[AW'(in_key_index)] <= in_key_time;
		rd_data_q <= key_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			key_count_q <= '0;
		else if (cfg_valid)
			key_count_q <= cfg_data;
	end

	always_comb begin
		off_c = (t_q > prev_q) ? t_q - prev_q : '0;
		gap_c = rd_data_q - prev_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q    <= in_pass_time;
			loop_q <= in_loop;
		end
		if (cmd.lat_end)
			end_q <= rd_data_q;
		if (cmd.lat_first)
			prev_q <= rd_data_q;
		if (cmd.set_one)
			idx_q <= CNT_W'(1);
		if (cmd.mod_take)
			t_q <= div_rem;
		if (cmd.step) begin
			prev_q <= rd_data_q;
			idx_q  <= idx_q + CNT_W'(1);
		end
		if (cmd.start_frac) begin
			gap_q <= gap_c;
			off_q <= off_c;
		end
	end

	// frac: the upper offset bits never exceed the gap, so preload them
	always_comb begin
		div_start = cmd.start_mod | cmd.start_frac;
		if (cmd.start_frac) begin
			div_init_rem = {1'b0, off_c[TIME_W-1:1]};
			div_init_dvd = {off_c[0], {(TIME_W-1){1'b0}}};
			div_divisor  = gap_c;
			div_steps    = FRAC_STEPS;
		end else begin
			div_init_rem = '0;
			div_init_dvd = t_q;
			div_divisor  = end_q;
			div_steps    = MOD_STEPS;
		end
	end

	kfsl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem (div_init_rem),
		.init_dvd (div_init_dvd),
		.divisor  (div_divisor),
		.steps    (div_steps),
		.done     (div_done),
		.rem      (div_rem),
		.quo      (div_quo)
	);

	always_comb begin
		res_status_d = 1'b0;
		res_base_d   = '0;
		res_next_d   = '0;
		res_frac_d   = '0;
		res_rest_d   = '0;
		res_gap_d    = '0;
		case (cmd.res_sel)
			RES_ZERO: begin
			end
			RES_EMPTY: begin
				res_status_d = 1'b1;
			end
			RES_FIRST: begin
				res_frac_d = FRAC_ONE;
			end
			RES_LAST: begin
				res_base_d = last_idx[KIDX_W-1:0];
				res_next_d = last_idx[KIDX_W-1:0];
				res_frac_d = FRAC_ONE;
			end
			RES_HIT: begin
				res_base_d = idx_q[KIDX_W-1:0];
				res_next_d = idx_q[KIDX_W-1:0];
				res_frac_d = FRAC_ONE;
			end
			RES_INTERP: begin
				res_base_d = idx_q[KIDX_W-1:0] - KIDX_W'(1);
				res_next_d = idx_q[KIDX_W-1:0];
				res_frac_d = div_quo;
				res_rest_d = gap_q - off_q;
				res_gap_d  = gap_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= res_status_d;
			res_base_q   <= res_base_d;
			res_next_q   <= res_next_d;
			res_frac_q   <= res_frac_d;
			res_rest_q   <= res_rest_d;
			res_gap_q    <= res_gap_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (cmd.out_load)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_status_q <= res_status_q;
			m_tdata_q  <= {7'b0, res_gap_q, res_rest_q, res_frac_q, res_next_q, res_base_q};
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_status_q;

	always_comb begin
		sts.in_lookup = s_tuser[0];
		sts.n_zero    = (n_act == '0);
		sts.early     = (n_act == CNT_W'(1)) || (end_q == '0) || (t_q < rd_data_q);
		sts.past_end  = (t_q >= end_q);
		sts.loop_on   = loop_q;
		sts.hit       = (t_q <= rd_data_q);
		sts.at_last   = (idx_q == last_idx);
		sts.inverted  = (rd_data_q <= prev_q);
		sts.div_done  = div_done;
		sts.out_busy  = m_tvalid_q && !m_tready;
	end

endmodule

// ===== hdl/kfsl_ctrl.sv =====
// -----------------------------------------------------------------------------
// kfsl_ctrl
// Lookup sequencer: end/first key fetch, wrap, linear key scan, fraction.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kfsl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	input  kfsl_pkg::sts_t  sts,
	output kfsl_pkg::cmd_t  cmd,
	output logic            s_tready
);
	import kfsl_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_END   = 3'd1;
	localparam logic [2:0] ST_FIRST = 3'd2;
	localparam logic [2:0] ST_MOD   = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_FRAC  = 3'd5;
	localparam logic [2:0] ST_DONE  = 3'd6;

	logic [2:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.rd_sel = RD_LAST;
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					if (!sts.in_lookup) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_ZERO;
						state_d      = ST_DONE;
					end else if (sts.n_zero) begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_EMPTY;
						state_d      = ST_DONE;
					end else begin
						state_d = ST_END;
					end
				end
			end
			ST_END: begin
				cmd.lat_end = 1'b1;
				cmd.rd_sel  = RD_ZERO;
				state_d     = ST_FIRST;
			end
			ST_FIRST: begin
				cmd.lat_first = 1'b1;
				cmd.set_one   = 1'b1;
				cmd.rd_sel    = RD_ONE;
				if (sts.early) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_FIRST;
					state_d      = ST_DONE;
				end else if (sts.past_end) begin
					if (sts.loop_on) begin
						cmd.start_mod = 1'b1;
						state_d       = ST_MOD;
					end else begin
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_LAST;
						state_d      = ST_DONE;
					end
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_MOD: begin
				cmd.rd_sel = RD_ONE;
				if (sts.div_done) begin
					cmd.mod_take = 1'b1;
					state_d      = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd_sel = RD_NEXT;
				if (sts.at_last || (sts.hit && sts.inverted)) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HIT;
					state_d      = ST_DONE;
				end else if (sts.hit) begin
					cmd.start_frac = 1'b1;
					state_d        = ST_FRAC;
				end else begin
					cmd.step = 1'b1;
				end
			end
			ST_FRAC: begin
				if (sts.div_done) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_INTERP;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign s_tready = (state_q == ST_IDLE);

endmodule

// ===== hdl/keyframe_segment_lookup.sv =====
// -----------------------------------------------------------------------------
// keyframe_segment_lookup
// Keyframe time table with segment lookup and Q1.16 interpolation weight.
// -----------------------------------------------------------------------------
// Channels: s_* takes one item per transfer (tuser = kind; kind 0 writes a key
// time, kind 1 looks up a pass time). m_* returns exactly one result per item
// (tuser = status, 1 for an empty table). cfg_* sets key_count, idle only, a
// rule for the user that the block leaves unenforced. One item at a time: a
// write or an empty-table lookup goes from IDLE straight to DONE, an early-out
// lookup through END and FIRST to DONE. A full lookup passes END, FIRST, MOD
// for the wrap remainder in loop mode only, SCAN (one table entry read per
// cycle on the single read port), FRAC for the fraction divide when it
// interpolates, then DONE. Both divides run on one shared radix-2 divider.
// Reset: key_count clears to zero, the output empties; table contents are
// undefined until written, no clearing pass.
// Stall: a finished result sits in the output register; the next item is
// accepted meanwhile and waits in its final state until the register frees.
// -----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyframe_segment_lookup_assert.svh"

module keyframe_segment_lookup #(
	parameter int MAX_KEYS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [3:0] key_index, [35:4] key_time, [67:36] pass_time, [68] loop_enable
	input  logic [kfsl_pkg::IN_TDATA_W-1:0]   s_tdata,
	// [0] kind
	input  logic [0:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [3:0] base_index, [7:4] next_index, [24:8] lerp_fraction,
	// [56:25] rest_time, [88:57] step_gap
	output logic [kfsl_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// [0] status
	output logic [0:0]                        m_tuser,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [kfsl_pkg::CNT_W-1:0]        cfg_data
);
	import kfsl_pkg::*;

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	kfsl_datapath #(
		.MAX_KEYS (MAX_KEYS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	kfsl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.sts      (sts),
		.cmd      (cmd),
		.s_tready (s_tready)
	);

	`KFSL_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.out_load, !(m_tvalid && !m_tready), "result overwritten while stalled")
	`KFSL_ASSERT_NXT(a_busy_after_in, clk, arst_n, s_tvalid && s_tready, !s_tready, "input taken twice in a row")
	`KFSL_ASSERT_IMP(a_cmd_excl, clk, arst_n, 1'b1, $onehot0({cmd.start_mod, cmd.start_frac, cmd.out_load}), "conflicting commands")

endmodule

// ===== test/keyframe_segment_lookup_checker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// keyframe_segment_lookup_checker
// Watches the item, result and key-count channels. Keeps its own copy of the
// key table and key count, predicts the result of every transfer on the item
// channel, and compares each result transfer field by field, oldest first.
// -----------------------------------------------------------------------------

module keyframe_segment_lookup_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [kfsl_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                       s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [kfsl_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic [0:0]                       m_tuser,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [kfsl_pkg::CNT_W-1:0]       cfg_data,
	output int                               fail_count,
	output int                               pending
);
	import kfsl_pkg::*;

	localparam int KEYS = 16;

	typedef struct packed {
		logic              status;
		logic [KIDX_W-1:0] base_index;
		logic [KIDX_W-1:0] next_index;
		logic [FRAC_W-1:0] lerp_fraction;
		logic [TIME_W-1:0] rest_time;
		logic [TIME_W-1:0] step_gap;
	} seg_result_t;

	logic [TIME_W-1:0] key_tab [KEYS];
	logic [CNT_W-1:0]  key_count;
	seg_result_t       segment_q [$];

	initial begin
		fail_count = 0;
		pending    = 0;
	end

	function automatic seg_result_t predict_segment(logic kind, logic [KIDX_W-1:0] idx,
			logic [TIME_W-1:0] new_time, logic [TIME_W-1:0] t_in, logic wrap);
		seg_result_t       r;
		int unsigned       n;
		int unsigned       last;
		int unsigned       i;
		logic [TIME_W-1:0] t;
		logic [TIME_W-1:0] end_t;
		logic [TIME_W-1:0] prev;
		logic [TIME_W-1:0] cur;
		logic [TIME_W-1:0] span;
		logic [TIME_W-1:0] off;
		logic [47:0]       num;
		r = '0;
		n = (key_count > KEYS) ? KEYS : key_count;
		if (!kind) begin
			if (idx < n)
				key_tab[idx] = new_time;
			return r;
		end
		if (n == 0) begin
			r.status = 1'b1;
			return r;
		end
		last  = n - 1;
		end_t = key_tab[last];
		t     = t_in;
		if (n == 1 || end_t == 0 || t < key_tab[0]) begin
			r.lerp_fraction = FRAC_ONE;
			return r;
		end
		if (t >= end_t) begin
			if (!wrap) begin
				r.base_index    = last[KIDX_W-1:0];
				r.next_index    = last[KIDX_W-1:0];
				r.lerp_fraction = FRAC_ONE;
				return r;
			end
			t = t % end_t;
		end
		// first key at or above t; the last key always qualifies
		i = 1;
		while (i < last && t > key_tab[i])
			i++;
		prev = key_tab[i-1];
		cur  = key_tab[i];
		if (i == last || cur <= prev) begin
			r.base_index    = i[KIDX_W-1:0];
			r.next_index    = i[KIDX_W-1:0];
			r.lerp_fraction = FRAC_ONE;
			return r;
		end
		span = cur - prev;
		off  = (t > prev) ? t - prev : '0;
		if (off > span)
			off = span;
		num             = {off, 16'h0000};
		r.base_index    = i[KIDX_W-1:0] - KIDX_W'(1);
		r.next_index    = i[KIDX_W-1:0];
		r.lerp_fraction = FRAC_W'(num / span);
		r.rest_time     = span - off;
		r.step_gap      = span;
		return r;
	endfunction

	task automatic check_field(string fname, longint unsigned want, longint unsigned seen);
		if (want != seen) begin
			$error("%s: expected %0d, got %0d", fname, want, seen);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_result_t want;
		if (!arst_n) begin
			key_count = '0;
			segment_q.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				key_count = cfg_data;
			// retire before pushing so a stray result never pairs with a fresh item
			if (m_tvalid && m_tready) begin
				if (segment_q.size() == 0) begin
					$error("result transfer with no item outstanding");
					fail_count++;
				end else begin
					want = segment_q.pop_front();
					check_field("status", want.status, m_tuser[0]);
					check_field("base_index", want.base_index, m_tdata[3:0]);
					check_field("next_index", want.next_index, m_tdata[7:4]);
					check_field("lerp_fraction", want.lerp_fraction, m_tdata[24:8]);
					check_field("rest_time", want.rest_time, m_tdata[56:25]);
					check_field("step_gap", want.step_gap, m_tdata[88:57]);
				end
			end
			if (s_tvalid && s_tready)
				segment_q.push_back(predict_segment(s_tuser[0], s_tdata[3:0],
					s_tdata[35:4], s_tdata[67:36], s_tdata[68]));
			pending = segment_q.size();
		end
	end

endmodule

// ===== test/keyframe_segment_lookup_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// keyframe_segment_lookup_tb
// Loads key tables of sizes from empty to full, ascending, with repeated
// keys, unordered and mostly zero, then runs directed and shaped random lookups
// and key writes under varying source and sink throttling plus one long sink
// stall. A separate checker predicts and compares every result.
// -----------------------------------------------------------------------------

module keyframe_segment_lookup_tb;
	import kfsl_pkg::*;

	localparam int ITEM_TARGET = 800;
	localparam int KEYS        = 16;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata   = '0;
	logic [0:0]             s_tuser   = '0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CNT_W-1:0]       cfg_data  = '0;

	int fail_count;
	int pending;

	int src_idle_pct = 15;
	int snk_idle_pct = 82;
	bit hold_req     = 1'b0;
	bit snk_hold     = 1'b0;

	logic [TIME_W-1:0] key_mirror [KEYS];
	int n_keys      = 0;
	int transfers   = 0;
	int lookups     = 0;
	int rand_items  = 0;
	int table_loads = 0;

	always #6 clk = ~clk;

	keyframe_segment_lookup #(.MAX_KEYS(KEYS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	keyframe_segment_lookup_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always @(negedge clk) begin
		if (!arst_n || snk_hold)
			m_tready <= 1'b0;
		else
			m_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	// long sink stall, counted on rising edges so the sink sees a settled flag
	initial begin
		wait (hold_req);
		@(posedge clk);
		snk_hold = 1'b1;
		repeat (300) @(posedge clk);
		snk_hold = 1'b0;
	end

	initial begin
		#10_000_000;
		$error("run did not finish in time, %0d results outstanding", pending);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	task automatic send_item(logic kind, logic [KIDX_W-1:0] idx, logic [TIME_W-1:0] new_time,
			logic [TIME_W-1:0] t, logic wrap);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {3'b000, wrap, t, new_time, idx};
		do @(posedge clk); while (!s_tready);
		transfers++;
	endtask

	task automatic write_key(int idx, logic [TIME_W-1:0] val);
		if (idx < n_keys)
			key_mirror[idx] = val;
		send_item(1'b0, KIDX_W'(idx), val, $urandom, 1'($urandom_range(1)));
	endtask

	task automatic look_up(logic [TIME_W-1:0] t, logic wrap);
		lookups++;
		send_item(1'b1, KIDX_W'($urandom_range(15)), $urandom, t, wrap);
	endtask

	task automatic set_key_count(int n);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= CNT_W'(n);
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_keys = n;
	endtask

	function automatic logic [TIME_W-1:0] pick_time();
		int unsigned       j;
		logic [TIME_W-1:0] lo;
		logic [TIME_W-1:0] hi;
		if (n_keys == 0)
			return $urandom;
		j  = $urandom_range(0, n_keys - 1);
		lo = key_mirror[j];
		hi = key_mirror[(j + 1 < n_keys) ? j + 1 : j];
		case ($urandom_range(7))
			0: return $urandom;
			1: return lo;
			2: return lo + 1'b1;
			3: return lo - 1'b1;
			4, 5: begin
				if (hi > lo)
					return TIME_W'(longint'($urandom) % (longint'(hi) - lo + 1) + lo);
				return lo;
			end
			6: return key_mirror[n_keys-1] + $urandom_range(0, 32'h4_0000);
			default: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
	endfunction

	task automatic load_table(int n);
		int                style;
		int                k;
		logic [TIME_W-1:0] acc;
		logic [TIME_W-1:0] vals [KEYS];
		style = $urandom_range(4);
		acc   = (style == 1) ? $urandom_range(0, 32'h0FFF_FFFF) : $urandom_range(0, 32'h3_0000);
		for (k = 0; k < n; k++) begin
			case (style)
				0: begin
					vals[k] = acc;
					acc += $urandom_range(1, 32'h2_0000);
				end
				1: begin
					vals[k] = acc;
					acc += $urandom_range(0, 32'h0FFF_FFFF);
				end
				2: begin
					vals[k] = acc;
					if ($urandom_range(2) != 0)
						acc += $urandom_range(1, 32'h800);
				end
				3: vals[k] = $urandom;
				default: vals[k] = ($urandom_range(3) == 0) ? $urandom_range(0, 32'h1_0000) : '0;
			endcase
		end
		if (n > 0 && style == 1 && $urandom_range(1))
			vals[n-1] = 32'hFFFF_FFFF;
		set_key_count(n);
		for (k = 0; k < n; k++)
			write_key(k, vals[k]);
		table_loads++;
	endtask

	initial begin
		int n;
		int k;
		int r;
		int per_set;
		int w;
		int idx;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty table, ignored write
		set_key_count(0);
		look_up(32'h0, 1'b0);
		write_key(0, 32'h1234_5678);
		look_up(32'hFFFF_FFFF, 1'b1);
		// end time zero
		set_key_count(2);
		write_key(0, 32'h0);
		write_key(1, 32'h0);
		look_up(32'h5, 1'b1);
		// single key
		set_key_count(1);
		write_key(0, 32'h5_0000);
		look_up(32'h6_0000, 1'b1);
		// zero gap, final segment, before first key
		set_key_count(3);
		write_key(0, 32'h1_0000);
		write_key(1, 32'h1_0000);
		write_key(2, 32'h3_0000);
		look_up(32'h1_0000, 1'b0);
		look_up(32'h2_0000, 1'b0);
		look_up(32'h0_8000, 1'b0);
		// inverted gap after wrap, past end without wrap, interior
		set_key_count(4);
		write_key(0, 32'h5_0000);
		write_key(1, 32'h3_0000);
		write_key(2, 32'h7_0000);
		write_key(3, 32'h8_0000);
		look_up(32'h9_0000, 1'b1);
		look_up(32'h9_0000, 1'b0);
		look_up(32'h6_0000, 1'b1);
		look_up(32'h8_0000, 1'b1);

		k = 0;
		while (rand_items < ITEM_TARGET) begin
			case (k % 6)
				0: n = KEYS;
				1: n = 0;
				2: n = 1;
				3: n = 2;
				default: n = $urandom_range(3, KEYS - 1);
			endcase
			k++;
			load_table(n);
			rand_items += n;
			per_set = $urandom_range(20, 50);
			for (w = 0; w < per_set; w++) begin
				if (rand_items < ITEM_TARGET / 3) begin
					src_idle_pct = 15;
					snk_idle_pct = 82;
				end else if (rand_items < 2 * ITEM_TARGET / 3) begin
					src_idle_pct = 82;
					snk_idle_pct = 15;
				end else begin
					src_idle_pct = 0;
					snk_idle_pct = 0;
					hold_req = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 75) begin
					look_up(pick_time(), $urandom_range(3) != 0);
					rand_items++;
				end else if (r < 90 && n > 0) begin
					idx = $urandom_range(0, n - 1);
					write_key(idx, pick_time());
					rand_items++;
				end else begin
					idx = $urandom_range(15);
					write_key(idx, $urandom);
					if (idx < n)
						rand_items++;
				end
			end
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		for (w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
		repeat (100) @(negedge clk);
		if (pending != 0)
			$error("%0d results never arrived", pending);

		$display("covered %0d transfers, %0d of them lookups, over %0d key tables",
			transfers, lookups, table_loads);
		$display("sizes from empty to full, with throttled, stalled and free-running sink");
		if (fail_count == 0 && pending == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
